/* sv/sts_pkg.sv */
// Package: shared types, constants and segment tables for the serializer.
`default_nettype none
package sts_pkg;

  localparam int FRAME_BITS = 24;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);

  localparam logic [9:0] MAX_VALUE  = 10'd999;
  localparam logic [9:0] BLANK_CODE = 10'd10;
  localparam logic [3:0] BLANK_DIG  = 4'd10;

  typedef struct packed {
    logic       blank;
    logic [3:0] hund;
    logic [6:0] rem;
  } digit_split_t;

  typedef struct packed {
    logic seg;
    logic last;
  } cell_data_t;

  function automatic logic [7:0] hund_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h0C;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h5E;
      4'd4:    s = 8'h6C;
      4'd5:    s = 8'h76;
      4'd6:    s = 8'hF7;
      4'd7:    s = 8'h1C;
      4'd8:    s = 8'hFF;
      4'd9:    s = 8'hFE;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] tens_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h7E;
      4'd1:    s = 8'h30;
      4'd2:    s = 8'h6D;
      4'd3:    s = 8'h79;
      4'd4:    s = 8'h33;
      4'd5:    s = 8'h5B;
      4'd6:    s = 8'h5F;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'hFF;
      4'd9:    s = 8'h7B;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] ones_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h7F;
      4'd1:    s = 8'h30;
      4'd2:    s = 8'hEC;
      4'd3:    s = 8'hF8;
      4'd4:    s = 8'hB2;
      4'd5:    s = 8'hDA;
      4'd6:    s = 8'hDE;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'hFF;
      4'd9:    s = 8'hFA;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* sv/three_digit_seven_segment_serializer.sv */
// Top level: digit split, segment lookup and the 24-cell output shift chain.
//
// Each accepted value becomes a 24-bit segment frame (hundreds byte lowest)
// that leaves as 24 result transactions, least significant bit first, with
// out_last_bit set on the final one. Values above 999 show 999; the value 10
// blanks all digits. A value is registered in the input stage, then is
// loaded into the shift chain when the chain is empty or its last bit is
// being taken, so with out_ready held high and a value waiting a new frame
// follows with no gap; the chain shifts one bit per cycle while out_ready is high.
`default_nettype none
module three_digit_seven_segment_serializer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [9:0] in_display_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_serial_bit,
  output logic            out_last_bit
);

  localparam int NB = sts_pkg::FRAME_BITS;
  localparam int CW = sts_pkg::CNT_W;

  logic                  split_valid;
  sts_pkg::digit_split_t split_data;
  logic                  load, shift;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [14:0]           tprod;
  logic [3:0]            tens, ones, hd, td, od;
  logic [6:0]            ones_full;
  logic [NB-1:0]         frame;
  sts_pkg::cell_data_t   cell_q [NB+1];

  sts_split u_split (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_display_value (in_display_value),
    .take             (load),
    .split_valid      (split_valid),
    .split_data       (split_data)
  );

  assign out_valid = (cnt_r != '0);
  assign load  = split_valid && ((cnt_r == '0) || ((cnt_r == CW'(1)) && out_ready));
  assign shift = out_valid && out_ready;

  always_comb begin
    tprod     = 15'(split_data.rem) * 15'd205;
    tens      = tprod[14:11];
    ones_full = split_data.rem - 7'(tens) * 7'd10;
    ones      = ones_full[3:0];
    hd = split_data.blank ? sts_pkg::BLANK_DIG : split_data.hund;
    td = split_data.blank ? sts_pkg::BLANK_DIG : tens;
    od = split_data.blank ? sts_pkg::BLANK_DIG : ones;
    frame = {sts_pkg::ones_seg(od), sts_pkg::tens_seg(td), sts_pkg::hund_seg(hd)};
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = CW'(NB);
    end else if (shift) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cell_q[NB] = '{seg: 1'b0, last: 1'b0};

  for (genvar k = 0; k < NB; k++) begin : g_cell
    sts_pkg::cell_data_t ld;
    assign ld.seg  = frame[k];
    assign ld.last = (k == NB - 1);
    sts_cell u_cell (
      .clk       (clk),
      .load      (load),
      .shift     (shift),
      .load_data (ld),
      .next_data (cell_q[k+1]),
      .data      (cell_q[k])
    );
  end

  assign out_serial_bit = cell_q[0].seg;
  assign out_last_bit   = cell_q[0].last;

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_bit == (cnt_r == CW'(1))))
    else $error("last flag out of step with bit count");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NB))
    else $error("bit count above frame length");

  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == CW'(NB)))
    else $error("frame load did not set full count");

endmodule
`default_nettype wire

/* sv/sts_split.sv */
// Input stage: saturate the value, flag the blank code and split off the hundreds digit.
`default_nettype none
module sts_split (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [9:0]           in_display_value,
  input  wire logic                 take,
  output logic                      split_valid,
  output sts_pkg::digit_split_t     split_data
);

  logic                  valid_r, valid_nxt;
  sts_pkg::digit_split_t data_r, data_nxt;
  logic [9:0]            sat;
  logic [15:0]           hprod;
  logic [3:0]            hund;
  logic [9:0]            rem_full;

  assign in_ready = !valid_r || take;

  always_comb begin
    sat      = (in_display_value > sts_pkg::MAX_VALUE) ? sts_pkg::MAX_VALUE
                                                       : in_display_value;
    hprod    = 16'(sat) * 16'd41;
    hund     = hprod[15:12];
    rem_full = sat - 10'(hund) * 10'd100;
    data_nxt.blank = (sat == sts_pkg::BLANK_CODE);
    data_nxt.hund  = hund;
    data_nxt.rem   = rem_full[6:0];
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign split_valid = valid_r;
  assign split_data  = data_r;

endmodule
`default_nettype wire

/* sv/sts_cell.sv */
// Shift cell: one frame bit and its last flag, loaded in parallel or shifted.
`default_nettype none
module sts_cell (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic               shift,
  input  wire sts_pkg::cell_data_t load_data,
  input  wire sts_pkg::cell_data_t next_data,
  output sts_pkg::cell_data_t     data
);

  sts_pkg::cell_data_t data_r, data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

/* test/tb_three_digit_seven_segment_serializer.sv */
// Testbench: random and directed display values, bit-serial frames checked against a predictor.
`timescale 1ns / 100ps
module tb_three_digit_seven_segment_serializer;

  localparam int          RANDOM_VALUES = 457;
  localparam int          IDLE_PCT      = 22;
  localparam int unsigned QUIET_FROM    = 5000;
  localparam int unsigned QUIET_TO      = 8000;
  localparam int          HOLD_AT       = 100;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_AT      = 200;
  localparam int          TAIL_CYCLES   = 60;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // segment maps, entry 0 in the low byte, entry 10 is blank
  localparam logic [87:0] HUND_MAP = {8'h00, 8'hFE, 8'hFF, 8'h1C, 8'hF7, 8'h76,
                                      8'h6C, 8'h5E, 8'h5B, 8'h0C, 8'h3F};
  localparam logic [87:0] TENS_MAP = {8'h00, 8'h7B, 8'hFF, 8'h70, 8'h5F, 8'h5B,
                                      8'h33, 8'h79, 8'h6D, 8'h30, 8'h7E};
  localparam logic [87:0] ONES_MAP = {8'h00, 8'hFA, 8'hFF, 8'h70, 8'hDE, 8'hDA,
                                      8'hB2, 8'hF8, 8'hEC, 8'h30, 8'h7F};

  typedef struct {
    logic serial_bit;
    logic last_bit;
  } frame_bit_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [9:0] in_display_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_serial_bit;
  logic       out_last_bit;

  logic [9:0]  values_to_send[$];
  frame_bit_t  frame_bits_due[$];
  int unsigned cycle_count = 0;
  int          values_taken = 0;
  int          mismatch_count = 0;
  logic        value_taken_now = 1'b0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  three_digit_seven_segment_serializer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_display_value (in_display_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_serial_bit   (out_serial_bit),
    .out_last_bit     (out_last_bit)
  );

  always #1 clk = ~clk;

  function automatic logic [23:0] segment_frame(input logic [9:0] value);
    int v;
    int h;
    int t;
    int o;
    v = (value > sts_pkg::MAX_VALUE) ? int'(sts_pkg::MAX_VALUE) : int'(value);
    if (v == int'(sts_pkg::BLANK_CODE)) begin
      h = int'(sts_pkg::BLANK_DIG);
      t = int'(sts_pkg::BLANK_DIG);
      o = int'(sts_pkg::BLANK_DIG);
    end else begin
      h = v / 100;
      t = (v / 10) % 10;
      o = v % 10;
    end
    return {ONES_MAP[o*8 +: 8], TENS_MAP[t*8 +: 8], HUND_MAP[h*8 +: 8]};
  endfunction

  function automatic logic [9:0] random_display_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 10'($urandom_range(999));
    if (pick < 80) return 10'($urandom_range(1023, 1000));
    if (pick < 88) return sts_pkg::BLANK_CODE;
    return 10'($urandom_range(1023));
  endfunction

  task automatic report_mismatch(input string what, input frame_bit_t want,
                                 input logic got_bit, input logic got_last);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0s at cycle %0d: expected bit=%b last=%b, got bit=%b last=%b",
               what, cycle_count, want.serial_bit, want.last_bit, got_bit, got_last);
    end
  endtask

  function automatic logic quiet_stretch();
    return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
  endfunction

  // sample both channels, check results, predict frames for accepted values
  always @(posedge clk) begin
    logic [23:0] frame;
    frame_bit_t  want;
    cycle_count <= cycle_count + 1;
    value_taken_now = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (frame_bits_due.size() == 0) begin
          want.serial_bit = 1'bx;
          want.last_bit   = 1'bx;
          report_mismatch("unexpected transaction", want, out_serial_bit, out_last_bit);
        end else begin
          want = frame_bits_due.pop_front();
          if (out_serial_bit !== want.serial_bit || out_last_bit !== want.last_bit)
            report_mismatch("field", want, out_serial_bit, out_last_bit);
        end
      end
      if (in_valid && in_ready) begin
        value_taken_now = 1'b1;
        values_taken <= values_taken + 1;
        frame = segment_frame(in_display_value);
        for (int k = 0; k < sts_pkg::FRAME_BITS; k++) begin
          want.serial_bit = frame[k];
          want.last_bit   = (k == sts_pkg::FRAME_BITS - 1);
          frame_bits_due.push_back(want);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // driver: once the current value is taken, present the next one or idle (random gaps, drain at DRAIN_AT)
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || value_taken_now) begin
      if (values_to_send.size() == 0 ||
          (values_taken == DRAIN_AT && frame_bits_due.size() != 0) ||
          (!quiet_stretch() && $urandom_range(99) < IDLE_PCT)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid         <= 1'b1;
        in_display_value <= values_to_send.pop_front();
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && values_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_stretch() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  initial begin
    logic [9:0] directed[];
    directed = '{10'd0, 10'd10, 10'd1, 10'd9, 10'd11, 10'd99, 10'd100,
                 10'd101, 10'd111, 10'd222, 10'd333, 10'd444, 10'd555,
                 10'd666, 10'd777, 10'd888, 10'd999, 10'd1000, 10'd1023,
                 10'd512, 10'd20, 10'd110, 10'd910};
    foreach (directed[i]) values_to_send.push_back(directed[i]);
    repeat (RANDOM_VALUES) values_to_send.push_back(random_display_value());
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (values_to_send.size() != 0 || in_valid || frame_bits_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frame_bits_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/sts_pkg.sv
sv/sts_split.sv
sv/sts_cell.sv
sv/three_digit_seven_segment_serializer.sv
test/tb_three_digit_seven_segment_serializer.sv
